>>> rtl/spd_pkg.sv
// Package for the slotted page directory: request and result structs and codes.
// No dependencies; used by every module in rtl.
package spd_pkg;

    localparam logic [1:0] REQ_ADD = 2'd0;
    localparam logic [1:0] REQ_DEL = 2'd1;
    localparam logic [1:0] REQ_GET = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_RANGE    = 3'd1;
    localparam logic [2:0] ST_NO_SLOT  = 3'd2;
    localparam logic [2:0] ST_NO_SPACE = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  slot_index;
        logic [15:0] record_length;
    } request_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  result_slot;
        logic [15:0] result_offset;
        logic [15:0] result_length;
        logic        did_compact;
    } result_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLR_ACC,
        OP_SCAN,
        OP_PLACE,
        OP_CPY,
        OP_RANK_CLR,
        OP_RANK,
        OP_RANK_WR,
        OP_DELETE,
        OP_GET
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [7:0] i_idx;
        logic [7:0] j_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic        found_free;
        logic [7:0]  free_slot;
        logic        fits;
        logic        free_ok;
        logic        live_i;
        logic        place_ok;
    } dp_status_t;

endpackage

>>> rtl/spd_datapath.sv
// Datapath of the slotted page directory: slot tables, accumulators, rank unit.
// Depends on spd_pkg; driven by spd_controller.
module spd_datapath #(
    parameter int NUM_SLOTS    = 32,
    parameter int PAGE_BYTES   = 4096,
    parameter int HEADER_BYTES = 192
) (
    input  logic                clk,
    input  logic                rst_n,
    input  spd_pkg::dp_cmd_t    cmd,
    input  spd_pkg::request_t   req,
    output spd_pkg::dp_status_t stat,
    output logic [15:0]         get_offset,
    output logic [15:0]         get_length,
    output logic [15:0]         place_offset
);
    import spd_pkg::*;

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CAP = (PAGE_BYTES > HEADER_BYTES) ? PAGE_BYTES - HEADER_BYTES : 0;

    logic [NUM_SLOTS-1:0] live_reg;
    logic [15:0] off_mem [NUM_SLOTS];
    logic [15:0] len_mem [NUM_SLOTS];
    logic [15:0] old_mem [NUM_SLOTS];
    logic [23:0] used_reg;
    logic [16:0] tail_reg;
    logic        found_reg;
    logic [7:0]  free_reg;
    logic [23:0] pos_reg;

    logic [IW-1:0] ii, jj;
    assign ii = cmd.i_idx[IW-1:0];
    assign jj = cmd.j_idx[IW-1:0];

    logic [16:0] end_j;
    logic        before_j;
    logic [17:0] need;
    assign end_j    = {1'b0, off_mem[jj]} + {1'b0, len_mem[jj]};
    assign before_j = live_reg[jj] && (cmd.j_idx != cmd.i_idx) &&
                      ((old_mem[jj] < old_mem[ii]) ||
                       ((old_mem[jj] == old_mem[ii]) && (cmd.j_idx < cmd.i_idx)));
    assign need = {1'b0, tail_reg} + {2'b0, req.record_length};

    assign stat.found_free = found_reg;
    assign stat.free_slot  = free_reg;
    assign stat.fits       = (need <= 18'(PAGE_BYTES)) && (tail_reg <= 17'hFFFF);
    assign stat.free_ok    = ({8'b0, req.record_length} + used_reg) <= 24'(CAP);
    assign stat.live_i     = live_reg[ii];
    assign stat.place_ok   = stat.fits;
    assign get_offset      = off_mem[ii];
    assign get_length      = len_mem[ii];
    assign place_offset    = tail_reg[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg  <= '0;
            found_reg <= 1'b0;
            free_reg  <= '0;
            used_reg  <= '0;
            tail_reg  <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            unique case (cmd.op)
                OP_CLR_ACC, OP_RANK_WR:
                begin
                    found_reg <= 1'b0;
                    free_reg  <= '0;
                    used_reg  <= '0;
                    tail_reg  <= 17'(HEADER_BYTES);
                end
                OP_SCAN:
                begin
                    if (!live_reg[jj] && !found_reg)
                    begin
                        found_reg <= 1'b1;
                        free_reg  <= cmd.j_idx;
                    end
                    if (live_reg[jj])
                    begin
                        used_reg <= used_reg + 24'(len_mem[jj]);
                        if (end_j > tail_reg)
                            tail_reg <= end_j;
                    end
                end
                OP_PLACE:     live_reg[ii] <= 1'b1;
                OP_RANK_CLR:  pos_reg <= 24'(HEADER_BYTES);
                OP_RANK:
                begin
                    if (before_j)
                        pos_reg <= pos_reg + 24'(len_mem[jj]);
                end
                OP_DELETE:    live_reg[ii] <= 1'b0;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_PLACE:
            begin
                off_mem[ii] <= tail_reg[15:0];
                len_mem[ii] <= req.record_length;
            end
            OP_CPY:   old_mem[jj] <= off_mem[jj];
            OP_RANK_WR:
            begin
                if (live_reg[ii])
                    off_mem[ii] <= pos_reg[15:0];
            end
            default:
            begin
            end
        endcase
    end

endmodule

>>> rtl/spd_controller.sv
// Controller state machine of the slotted page directory.
// Depends on spd_pkg; sequences spd_datapath and drives the result strobe.
module spd_controller #(
    parameter int NUM_SLOTS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  spd_pkg::request_t   request,
    output logic                busy,
    output spd_pkg::request_t   req,
    output spd_pkg::dp_cmd_t    cmd,
    input  spd_pkg::dp_status_t stat,
    input  logic [15:0]         get_offset,
    input  logic [15:0]         get_length,
    input  logic [15:0]         place_offset,
    output logic                done,
    output spd_pkg::result_t    result
);
    import spd_pkg::*;

    localparam logic [7:0] LAST = 8'(NUM_SLOTS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_CPY, S_RCLR, S_RANK, S_RWR,
        S_RESCAN, S_REDECIDE
    } state_t;

    state_t      state_reg;
    request_t    req_reg;
    logic [7:0]  i_reg, j_reg;
    logic        done_reg;
    result_t     res_reg;

    assign busy   = (state_reg != S_IDLE);
    assign req    = req_reg;
    assign done   = done_reg;
    assign result = res_reg;

    always_comb
    begin
        cmd.op    = OP_NONE;
        cmd.i_idx = i_reg;
        cmd.j_idx = j_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.i_idx = request.slot_index;
                    if (request.req_type == REQ_ADD)
                        cmd.op = OP_CLR_ACC;
                    else if (request.req_type == REQ_DEL &&
                             {24'b0, request.slot_index} < 32'(NUM_SLOTS))
                        cmd.op = OP_DELETE;
                end
            end
            S_SCAN, S_RESCAN: cmd.op = OP_SCAN;
            S_DECIDE:
            begin
                cmd.i_idx = stat.free_slot;
                if (stat.found_free && stat.fits)
                    cmd.op = OP_PLACE;
            end
            S_REDECIDE:
            begin
                cmd.i_idx = i_reg;
                if (stat.fits)
                    cmd.op = OP_PLACE;
            end
            S_CPY:  cmd.op = OP_CPY;
            S_RCLR: cmd.op = OP_RANK_CLR;
            S_RANK: cmd.op = OP_RANK;
            S_RWR:  cmd.op = OP_RANK_WR;
            default: cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            req_reg   <= '0;
            res_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        req_reg <= request;
                        res_reg <= '{status: ST_OK, result_slot: request.slot_index,
                                     result_offset: '0, result_length: '0,
                                     did_compact: 1'b0};
                        i_reg <= request.slot_index;
                        j_reg <= '0;
                        if (request.req_type == REQ_ADD)
                            state_reg <= S_SCAN;
                        else
                        begin
                            done_reg <= 1'b1;
                            if (request.req_type == REQ_DEL)
                            begin
                                if ({24'b0, request.slot_index} >= 32'(NUM_SLOTS))
                                    res_reg.status <= ST_RANGE;
                            end
                            else if (request.req_type == REQ_GET)
                            begin
                                if ({24'b0, request.slot_index} >= 32'(NUM_SLOTS))
                                    res_reg.status <= ST_RANGE;
                                else if (!stat.live_i)
                                    res_reg.status <= ST_EMPTY;
                                else
                                begin
                                    res_reg.result_offset <= get_offset;
                                    res_reg.result_length <= get_length;
                                end
                            end
                            else
                                res_reg.status <= ST_RANGE;
                        end
                    end
                end
                S_SCAN, S_RESCAN:
                begin
                    j_reg <= j_reg + 8'd1;
                    if (j_reg == LAST)
                        state_reg <= (state_reg == S_SCAN) ? S_DECIDE : S_REDECIDE;
                end
                S_DECIDE:
                begin
                    j_reg <= '0;
                    i_reg <= stat.free_slot;
                    res_reg.result_slot <= stat.free_slot;
                    if (!stat.found_free)
                    begin
                        res_reg.status <= ST_NO_SLOT;
                        res_reg.result_slot <= '0;
                        done_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (stat.fits)
                    begin
                        res_reg.result_offset <= place_offset;
                        res_reg.result_length <= req_reg.record_length;
                        done_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (!stat.free_ok)
                    begin
                        res_reg.status <= ST_NO_SPACE;
                        done_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        res_reg.did_compact <= 1'b1;
                        state_reg <= S_CPY;
                    end
                end
                S_CPY:
                begin
                    j_reg <= j_reg + 8'd1;
                    if (j_reg == LAST)
                    begin
                        i_reg <= '0;
                        state_reg <= S_RCLR;
                    end
                end
                S_RCLR:
                begin
                    j_reg <= '0;
                    state_reg <= S_RANK;
                end
                S_RANK:
                begin
                    j_reg <= j_reg + 8'd1;
                    if (j_reg == LAST)
                        state_reg <= S_RWR;
                end
                S_RWR:
                begin
                    if (i_reg == LAST)
                    begin
                        i_reg <= res_reg.result_slot;
                        j_reg <= '0;
                        state_reg <= S_RESCAN;
                    end
                    else
                    begin
                        i_reg <= i_reg + 8'd1;
                        state_reg <= S_RCLR;
                    end
                end
                S_REDECIDE:
                begin
                    if (stat.fits)
                    begin
                        res_reg.result_offset <= place_offset;
                        res_reg.result_length <= req_reg.record_length;
                    end
                    else
                        res_reg.status <= ST_NO_SPACE;
                    done_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy) || $past(start))
        else $error("result strobe without a request");
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.req_type != REQ_ADD) |=> done)
        else $error("delete or get took more than one cycle");
    assert property (@(posedge clk) disable iff (!rst_n)
        done && result.did_compact |-> result.status != ST_NO_SLOT)
        else $error("compaction without a free slot");

endmodule

>>> rtl/slotted_page_directory.sv
// Top level of the slotted page directory: controller plus datapath.
// Depends on spd_pkg, spd_controller and spd_datapath.
// Delete and get: result in the cycle after start. Add: a scan of every slot, then a decision.
// Add with compaction also runs a rank pass that visits every slot pair through one adder;
// a new start is taken with the result. Reset empties every slot at once;
// the result cannot be stalled.
module slotted_page_directory #(
    parameter int NUM_SLOTS    = 32,
    parameter int PAGE_BYTES   = 4096,
    parameter int HEADER_BYTES = 192
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  spd_pkg::request_t  request,
    output logic               busy,
    output logic               done,
    output spd_pkg::result_t   result
);
    import spd_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t stat;
    request_t   req;
    logic [15:0] get_offset, get_length, place_offset;

    spd_controller #(.NUM_SLOTS(NUM_SLOTS)) u_ctrl (
        .clk, .rst_n, .start, .request, .busy, .req, .cmd, .stat,
        .get_offset, .get_length, .place_offset, .done, .result
    );

    spd_datapath #(
        .NUM_SLOTS(NUM_SLOTS), .PAGE_BYTES(PAGE_BYTES), .HEADER_BYTES(HEADER_BYTES)
    ) u_dp (
        .clk, .rst_n, .cmd, .req, .stat, .get_offset, .get_length, .place_offset
    );

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for slotted_page_directory: directed and random requests.
// Depends on spd_pkg and the RTL top; predicts each result and checks it on done.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import spd_pkg::*;

    localparam int NSLOT = 32;
    localparam int PAGE = 4096;
    localparam int HDR = 192;
    localparam int WATCH_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    request_t request = '0;
    logic busy;
    logic done;
    result_t result;

    slotted_page_directory #(
        .NUM_SLOTS(NSLOT),
        .PAGE_BYTES(PAGE),
        .HEADER_BYTES(HDR)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .request(request),
        .busy(busy),
        .done(done),
        .result(result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    bit dir_live [NSLOT];
    logic [15:0] dir_off [NSLOT];
    logic [15:0] dir_len [NSLOT];

    request_t pending_q[$];
    result_t expected_q[$];
    int errors = 0;
    int transfers = 0;
    int compactions = 0;
    int idle_ok = 1;
    bit hold_off = 1'b0;
    int quiet = 0;

    function automatic int unsigned page_tail();
        int unsigned t;
        t = HDR;
        for (int i = 0; i < NSLOT; i++)
            if (dir_live[i] && dir_off[i] + dir_len[i] > t)
                t = dir_off[i] + dir_len[i];
        return t;
    endfunction

    function automatic bit place_at_tail(int s, int unsigned len, output logic [15:0] off);
        int unsigned t;
        t = page_tail();
        off = '0;
        if (t + len > PAGE || t > 16'hFFFF)
            return 1'b0;
        dir_live[s] = 1'b1;
        dir_off[s] = t[15:0];
        dir_len[s] = len[15:0];
        off = t[15:0];
        return 1'b1;
    endfunction

    function automatic void pack_directory();
        logic [15:0] old_off [NSLOT];
        int unsigned pos;
        old_off = dir_off;
        for (int i = 0; i < NSLOT; i++)
        begin
            if (!dir_live[i])
                continue;
            pos = HDR;
            for (int j = 0; j < NSLOT; j++)
                if (j != i && dir_live[j] &&
                    (old_off[j] < old_off[i] || (old_off[j] == old_off[i] && j < i)))
                    pos += dir_len[j];
            dir_off[i] = pos[15:0];
        end
    endfunction

    function automatic result_t predict_result(request_t rq);
        result_t r;
        int s;
        int unsigned used;
        int unsigned freeb;
        logic [15:0] off;
        r = '0;
        r.status = ST_OK;
        r.result_slot = rq.slot_index;
        s = -1;
        if (rq.req_type == REQ_ADD)
        begin
            for (int i = NSLOT - 1; i >= 0; i--)
                if (!dir_live[i])
                    s = i;
            if (s < 0)
            begin
                r.status = ST_NO_SLOT;
                r.result_slot = '0;
            end
            else
            begin
                r.result_slot = s[7:0];
                if (place_at_tail(s, rq.record_length, off))
                begin
                    r.result_offset = off;
                    r.result_length = rq.record_length;
                end
                else
                begin
                    used = 0;
                    for (int i = 0; i < NSLOT; i++)
                        if (dir_live[i])
                            used += dir_len[i];
                    freeb = (PAGE - HDR > used) ? PAGE - HDR - used : 0;
                    if (rq.record_length > freeb)
                        r.status = ST_NO_SPACE;
                    else
                    begin
                        pack_directory();
                        r.did_compact = 1'b1;
                        if (place_at_tail(s, rq.record_length, off))
                        begin
                            r.result_offset = off;
                            r.result_length = rq.record_length;
                        end
                        else
                            r.status = ST_NO_SPACE;
                    end
                end
            end
        end
        else if (rq.req_type == REQ_DEL)
        begin
            if (rq.slot_index >= NSLOT)
                r.status = ST_RANGE;
            else
                dir_live[rq.slot_index] = 1'b0;
        end
        else if (rq.req_type == REQ_GET)
        begin
            if (rq.slot_index >= NSLOT)
                r.status = ST_RANGE;
            else if (!dir_live[rq.slot_index])
                r.status = ST_EMPTY;
            else
            begin
                r.result_offset = dir_off[rq.slot_index];
                r.result_length = dir_len[rq.slot_index];
            end
        end
        else
            r.status = ST_RANGE;
        return r;
    endfunction

    function automatic request_t make_request(logic [1:0] op, int idx, int len);
        request_t rq;
        rq.req_type = op;
        rq.slot_index = idx[7:0];
        rq.record_length = len[15:0];
        return rq;
    endfunction

    always @(posedge clk)
    begin
        if (start && !busy)
        begin
            expected_q.push_back(predict_result(request));
            transfers++;
        end
        if (start && !busy && pending_q.size() > 1 && !hold_off &&
            !(idle_ok && $urandom_range(99) < 7))
        begin
            request <= pending_q[1];
            void'(pending_q.pop_front());
        end
        else if (start && !busy)
        begin
            void'(pending_q.pop_front());
            start <= 1'b0;
        end
        else if (!start && rst_n && pending_q.size() > 0 && !hold_off &&
                 !(idle_ok && $urandom_range(99) < 7))
        begin
            request <= pending_q[0];
            start <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (done)
        begin
            quiet <= 0;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, result);
                errors++;
            end
            else
            begin
                if (result !== expected_q[0])
                begin
                    $display("%0t: mismatch expected %p actual %p",
                             $time, expected_q[0], result);
                    errors++;
                end
                if (expected_q[0].did_compact)
                    compactions++;
                void'(expected_q.pop_front());
            end
        end
        else if (start && !busy)
            quiet <= 0;
        else
            quiet <= quiet + 1;
    end

    always @(posedge clk)
    begin
        if (quiet >= WATCH_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < NSLOT; i++)
        begin
            dir_live[i] = 1'b0;
            dir_off[i] = 16'hFFFF;
            dir_len[i] = 16'hFFFF;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        pending_q.push_back(make_request(REQ_GET, 0, 0));
        pending_q.push_back(make_request(REQ_DEL, 5, 0));
        pending_q.push_back(make_request(REQ_GET, 255, 65535));
        pending_q.push_back(make_request(REQ_DEL, 32, 0));
        pending_q.push_back(make_request(2'd3, 17, 9));
        pending_q.push_back(make_request(REQ_ADD, 255, 65535));
        pending_q.push_back(make_request(REQ_ADD, 0, 0));
        pending_q.push_back(make_request(REQ_ADD, 0, 1000));
        pending_q.push_back(make_request(REQ_ADD, 0, 1500));
        pending_q.push_back(make_request(REQ_ADD, 0, 1000));
        pending_q.push_back(make_request(REQ_DEL, 1, 0));
        pending_q.push_back(make_request(REQ_ADD, 0, 900));
        pending_q.push_back(make_request(REQ_GET, 1, 0));
        pending_q.push_back(make_request(REQ_GET, 2, 0));
        pending_q.push_back(make_request(REQ_ADD, 0, 2000));
        pending_q.push_back(make_request(REQ_DEL, 0, 0));
        pending_q.push_back(make_request(REQ_DEL, 0, 0));
        pending_q.push_back(make_request(REQ_GET, 31, 0));
        for (int i = 0; i < 34; i++)
            pending_q.push_back(make_request(REQ_ADD, 0, i % 3));
        wait (pending_q.size() == 0);

        hold_off = 1'b1;
        wait (!start && expected_q.size() == 0);
        hold_off = 1'b0;

        for (int n = 0; n < 600; n++)
        begin
            int k;
            int ln;
            k = $urandom_range(99);
            if (n >= 200 && n < 320)
                idle_ok = 0;
            else
                idle_ok = 1;
            if (k < 15)
                ln = $urandom_range(65535);
            else if (k < 60)
                ln = $urandom_range(400);
            else
                ln = $urandom_range(40);
            k = $urandom_range(99);
            if (k < 45)
                pending_q.push_back(make_request(REQ_ADD, $urandom_range(255), ln));
            else if (k < 70)
                pending_q.push_back(make_request(REQ_DEL,
                    ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(31), ln));
            else if (k < 97)
                pending_q.push_back(make_request(REQ_GET,
                    ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(31), ln));
            else
                pending_q.push_back(make_request(2'd3, $urandom_range(255), ln));
            wait (pending_q.size() < 4);
        end
        wait (pending_q.size() == 0 && !start && expected_q.size() == 0);
        repeat (50) @(posedge clk);
        $display("Covered %0d transfers, %0d of them adds that compacted the page.",
                 transfers, compactions);
        if (errors == 0 && expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

>>> sim.f
rtl/spd_pkg.sv
rtl/spd_datapath.sv
rtl/spd_controller.sv
rtl/slotted_page_directory.sv
tb/sv/tb_top.sv
